// ----- rtl/core/life_automaton_grid_step_core_macros.svh -----
// assertion macros shared by the life grid step core
`ifndef LIFE_AUTOMATON_GRID_STEP_CORE_MACROS_SVH
`define LIFE_AUTOMATON_GRID_STEP_CORE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define LAGS_CHECK(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// condition that forces a consequence in the next cycle
`define LAGS_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lags_pkg.sv -----
// shared types and constants of the life grid step core
package lags_pkg;

    localparam int GRID_SIZE_DEF = 32;
    localparam int ROW_OUT_W     = 32;
    localparam int ROW_NUM_W     = 5;
    localparam int COORD_W       = 5;
    localparam int MAX_ROWS_OUT  = 32;

    typedef enum logic {
        OP_TOGGLE = 1'b0,
        OP_STEP   = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode              opcode;
        logic [COORD_W-1:0]   cell_row;
        logic [COORD_W-1:0]   cell_col;
    } t_in_item;

    typedef struct packed {
        logic [ROW_NUM_W-1:0] row_number;
        logic [ROW_OUT_W-1:0] row_cells;
        logic                 last_row;
    } t_out_item;

endpackage

// ----- rtl/core/lags_ram.sv -----
// generic single write port ram with registered read
module lags_ram #(
    parameter int WIDTH = lags_pkg::GRID_SIZE_DEF,
    parameter int DEPTH = lags_pkg::GRID_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/lags_row_unit.sv -----
// next generation of one row from the rows above, at and below it
module lags_row_unit #(
    parameter int GRID_SIZE = lags_pkg::GRID_SIZE_DEF
) (
    input  logic [GRID_SIZE-1:0] i_above,
    input  logic [GRID_SIZE-1:0] i_here,
    input  logic [GRID_SIZE-1:0] i_below,
    output logic [GRID_SIZE-1:0] o_next
);

    localparam logic [3:0] SURVIVE_CNT = 4'd2;
    localparam logic [3:0] BIRTH_CNT   = 4'd3;

    // one neighbour count per column, wrapping at the row ends
    for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
        localparam int L = (c == 0) ? GRID_SIZE - 1 : c - 1;
        localparam int R = (c == GRID_SIZE - 1) ? 0 : c + 1;
        logic [3:0] cnt;

        assign cnt = 4'(i_above[L]) + 4'(i_above[c]) + 4'(i_above[R])
                   + 4'(i_here[L])  + 4'(i_here[R])
                   + 4'(i_below[L]) + 4'(i_below[c]) + 4'(i_below[R]);

        assign o_next[c] = (cnt == BIRTH_CNT) || (i_here[c] && (cnt == SURVIVE_CNT));
    end

endmodule

// ----- rtl/core/life_automaton_grid_step_core.sv -----
// toroidal life grid: cell toggle and generation step over a row store
// toggle: the row is read when the request is taken, then S_TOG writes it back and loads the result
// once the output is free; step: the first min(GRID_SIZE, 32) new rows are loaded in row order
// the next request is taken once the sweep is back in idle; a stalled output pauses the sweep
// synchronous active-low reset clears the per-row valid bits at once: all cells dead
// a new request is taken in idle even while the last result still waits
module life_automaton_grid_step_core #(
    parameter int GRID_SIZE = lags_pkg::GRID_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lags_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lags_pkg::t_out_item o_out_data
);

`include "life_automaton_grid_step_core_macros.svh"

    localparam int AW        = $clog2(GRID_SIZE);
    localparam int CW        = $clog2(GRID_SIZE + 3);
    localparam int NOUT      = (GRID_SIZE < lags_pkg::MAX_ROWS_OUT) ?
                               GRID_SIZE : lags_pkg::MAX_ROWS_OUT;
    localparam logic [CW-1:0]        LAST_SLOT = CW'(GRID_SIZE + 2);
    localparam logic [CW-1:0]        FIRST_WR  = CW'(3);
    localparam logic [AW-1:0]        TOP_ROW   = AW'(GRID_SIZE - 1);
    localparam logic [GRID_SIZE-1:0] ROW_ONE   = GRID_SIZE'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TOG,
        S_STEP
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_slot, n_slot;
    logic [GRID_SIZE-1:0]  r_win_a, n_win_a;
    logic [GRID_SIZE-1:0]  r_win_h, n_win_h;
    logic [GRID_SIZE-1:0]  r_row0, n_row0;
    logic [GRID_SIZE-1:0]  r_valid, n_valid;
    logic                  r_rd_vld, n_rd_vld;
    logic [AW-1:0]         r_tog_row, n_tog_row;
    logic [GRID_SIZE-1:0]  r_tog_mask, n_tog_mask;
    logic                  r_out_valid, n_out_valid;
    lags_pkg::t_out_item   r_out, n_out;

    logic                  go;
    logic                  in_fire;
    logic                  tog_in_range;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [GRID_SIZE-1:0]  ram_q;
    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [GRID_SIZE-1:0]  ram_wr_data;
    logic [GRID_SIZE-1:0]  rd_row;
    logic [GRID_SIZE-1:0]  below_row;
    logic [GRID_SIZE-1:0]  next_row;
    logic [CW-1:0]         calc_row;

    // row store
    lags_ram #(
        .WIDTH (GRID_SIZE),
        .DEPTH (GRID_SIZE)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_q)
    );

    // shared next-generation unit
    lags_row_unit #(
        .GRID_SIZE (GRID_SIZE)
    ) u_row_unit (
        .i_above (r_win_a),
        .i_here  (r_win_h),
        .i_below (below_row),
        .o_next  (next_row)
    );

    // handshake and read data qualification
    assign go           = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE);
    assign in_fire      = i_in_valid && o_in_ready;
    assign tog_in_range = (int'(i_in_data.cell_row) < GRID_SIZE) &&
                          (int'(i_in_data.cell_col) < GRID_SIZE);
    assign rd_row       = r_rd_vld ? ram_q : '0;
    assign below_row    = (r_slot == LAST_SLOT) ? r_row0 : rd_row;
    assign calc_row     = r_slot - FIRST_WR;

    // sequencer next state, store access and output loading
    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_win_a     = r_win_a;
        n_win_h     = r_win_h;
        n_row0      = r_row0;
        n_valid     = r_valid;
        n_rd_vld    = r_rd_vld;
        n_tog_row   = r_tog_row;
        n_tog_mask  = r_tog_mask;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_rd_en   = 1'b0;
        ram_rd_addr = AW'(i_in_data.cell_row);
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_tog_row;
        ram_wr_data = rd_row ^ r_tog_mask;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.opcode == lags_pkg::OP_STEP) begin
                        n_state = S_STEP;
                        n_slot  = '0;
                    end else if (tog_in_range) begin
                        n_state    = S_TOG;
                        ram_rd_en  = 1'b1;
                        n_tog_row  = AW'(i_in_data.cell_row);
                        n_tog_mask = ROW_ONE << i_in_data.cell_col;
                    end
                end
            end
            S_TOG: begin
                if (go) begin
                    ram_wr_en            = 1'b1;
                    n_valid[r_tog_row]   = 1'b1;
                    n_out_valid          = 1'b1;
                    n_out.row_number     = lags_pkg::ROW_NUM_W'(r_tog_row);
                    n_out.row_cells      = lags_pkg::ROW_OUT_W'(ram_wr_data);
                    n_out.last_row       = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            S_STEP: begin
                if (go) begin
                    // issue reads: top row first, then rows from zero upward
                    if (int'(r_slot) <= GRID_SIZE) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = (r_slot == '0) ? TOP_ROW : AW'(r_slot - CW'(1));
                    end
                    // slide the three-row window over arriving old rows
                    if (r_slot != '0) begin
                        n_win_a = r_win_h;
                        n_win_h = below_row;
                    end
                    if (r_slot == CW'(2)) begin
                        n_row0 = rd_row;
                    end
                    // write back each new row and report those below the output row limit
                    if (r_slot >= FIRST_WR) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(calc_row);
                        ram_wr_data = next_row;
                        n_valid[AW'(calc_row)] = 1'b1;
                        if (int'(calc_row) < NOUT) begin
                            n_out_valid      = 1'b1;
                            n_out.row_number = lags_pkg::ROW_NUM_W'(calc_row);
                            n_out.row_cells  = lags_pkg::ROW_OUT_W'(next_row);
                            n_out.last_row   = (int'(calc_row) == NOUT - 1);
                        end
                    end
                    if (r_slot == LAST_SLOT) begin
                        n_state = S_IDLE;
                    end else begin
                        n_slot = r_slot + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ram_rd_en) begin
            n_rd_vld = r_valid[ram_rd_addr];
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_valid     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_valid     <= n_valid;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
        r_win_a    <= n_win_a;
        r_win_h    <= n_win_h;
        r_row0     <= n_row0;
        r_tog_row  <= n_tog_row;
        r_tog_mask <= n_tog_mask;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks on the sequencer
    `LAGS_CHECK(a_slot_bound, r_slot <= LAST_SLOT, "step slot counter overran")
    `LAGS_CHECK(a_no_wr_idle, !(ram_wr_en && (r_state == S_IDLE)), "row store written in idle")
    `LAGS_IMPLY(a_tog_result, (r_state == S_TOG) && go, o_out_valid && o_out_data.last_row, "toggle gave no final result")
    `LAGS_IMPLY(a_step_fills, (r_state == S_STEP) && go && (r_slot == LAST_SLOT), &r_valid, "step left rows unwritten")

endmodule

// ----- tb/life_automaton_grid_step_core_tb.sv -----
// self-checking testbench for the toroidal life grid step core
`timescale 1ns / 1ps

localparam int TB_GRID = lags_pkg::GRID_SIZE_DEF;

// tracks the live cells and holds the rows still owed by the core
class grid_row_tracker;
    bit [TB_GRID-1:0]    live_rows [TB_GRID];
    lags_pkg::t_out_item owed_rows [$];
    int                  errors;

    function new();
        for (int r = 0; r < TB_GRID; r++) live_rows[r] = '0;
        errors = 0;
    endfunction

    // next generation from a snapshot, wrapping at every edge
    function void advance_generation();
        bit [TB_GRID-1:0] prev [TB_GRID];
        int               up, dn, lf, rt, n;
        for (int r = 0; r < TB_GRID; r++) prev[r] = live_rows[r];
        for (int r = 0; r < TB_GRID; r++) begin
            up = (r + TB_GRID - 1) % TB_GRID;
            dn = (r + 1) % TB_GRID;
            for (int c = 0; c < TB_GRID; c++) begin
                lf = (c + TB_GRID - 1) % TB_GRID;
                rt = (c + 1) % TB_GRID;
                n = int'(prev[up][lf]) + int'(prev[up][c]) + int'(prev[up][rt])
                  + int'(prev[r][lf]) + int'(prev[r][rt])
                  + int'(prev[dn][lf]) + int'(prev[dn][c]) + int'(prev[dn][rt]);
                if (prev[r][c])
                    live_rows[r][c] = (n == 2 || n == 3);
                else
                    live_rows[r][c] = (n == 3);
            end
        end
    endfunction

    function void owe_row(input int r, input bit last);
        lags_pkg::t_out_item row;
        row.row_number = r[lags_pkg::ROW_NUM_W-1:0];
        row.row_cells  = live_rows[r];
        row.last_row   = last;
        owed_rows.push_back(row);
    endfunction

    // accepted request: update the grid and queue the rows it reports
    function void take_request(input lags_pkg::t_in_item req);
        int count;
        if (req.opcode == lags_pkg::OP_TOGGLE) begin
            if (req.cell_row >= TB_GRID || req.cell_col >= TB_GRID) return;
            live_rows[req.cell_row][req.cell_col] = ~live_rows[req.cell_row][req.cell_col];
            owe_row(int'(req.cell_row), 1'b1);
        end else begin
            advance_generation();
            count = (TB_GRID < lags_pkg::MAX_ROWS_OUT) ? TB_GRID : lags_pkg::MAX_ROWS_OUT;
            for (int r = 0; r < count; r++) owe_row(r, r == count - 1);
        end
    endfunction

    // accepted result against the oldest owed row
    function void check_row(input lags_pkg::t_out_item got);
        lags_pkg::t_out_item want;
        if (owed_rows.size() == 0) begin
            $display("%0t: unexpected row result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = owed_rows.pop_front();
        if (got.row_number !== want.row_number) begin
            $display("%0t: row_number mismatch, expected %0d, actual %0d",
                     $time, want.row_number, got.row_number);
            errors++;
        end
        if (got.row_cells !== want.row_cells) begin
            $display("%0t: row_cells mismatch on row %0d, expected %h, actual %h",
                     $time, want.row_number, want.row_cells, got.row_cells);
            errors++;
        end
        if (got.last_row !== want.last_row) begin
            $display("%0t: last_row mismatch on row %0d, expected %b, actual %b",
                     $time, want.row_number, want.last_row, got.last_row);
            errors++;
        end
    endfunction
endclass

module life_automaton_grid_step_core_tb;

    localparam int STALL_LIMIT = 4000;
    localparam int OUT_HOLD    = 400;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    lags_pkg::t_in_item  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    lags_pkg::t_out_item o_out_data;

    grid_row_tracker board;
    int              send_idle_pct = 6;
    int              recv_idle_pct = 45;
    int              out_hold_req  = 0;
    int              hold_left     = 0;
    int              stall_cycles  = 0;

    life_automaton_grid_step_core #(
        .GRID_SIZE(TB_GRID)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random back-pressure plus an occasional long hold
    initial begin
        forever begin
            @(posedge i_clk);
            if (out_hold_req > 0) begin
                hold_left    = out_hold_req;
                out_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // monitor both channels at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) board.take_request(i_in_data);
        if (i_rst_n && o_out_valid && i_out_ready) board.check_row(o_out_data);
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("life_automaton_grid_step_core_tb: errors");
            $finish;
        end
    end

    // offer one request, with random gaps first, and hold it until taken
    task automatic send_request(input lags_pkg::t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_toggle(input int r, input int c);
        lags_pkg::t_in_item req;
        req.opcode   = lags_pkg::OP_TOGGLE;
        req.cell_row = r[lags_pkg::COORD_W-1:0];
        req.cell_col = c[lags_pkg::COORD_W-1:0];
        send_request(req);
    endtask

    // coordinates of a step request are don't-care, so randomise them
    task automatic send_step();
        lags_pkg::t_in_item req;
        req.opcode   = lags_pkg::OP_STEP;
        req.cell_row = lags_pkg::COORD_W'($urandom_range(31));
        req.cell_col = lags_pkg::COORD_W'($urandom_range(31));
        send_request(req);
    endtask

    // sender pauses until every owed row has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.owed_rows.size() != 0) @(posedge i_clk);
    endtask

    // bursts of seeding toggles, mostly clustered, followed by a few steps
    task automatic run_random(input int count);
        int sent, burst, base_r, base_c, r, c;
        bit clustered;
        sent = 0;
        while (sent < count) begin
            burst     = $urandom_range(20, 2);
            clustered = ($urandom_range(99) < 75);
            base_r    = $urandom_range(TB_GRID - 1);
            base_c    = $urandom_range(TB_GRID - 1);
            repeat (burst) begin
                if (clustered) begin
                    r = (base_r + $urandom_range(5)) % TB_GRID;
                    c = (base_c + $urandom_range(5)) % TB_GRID;
                end else begin
                    r = $urandom_range(TB_GRID - 1);
                    c = $urandom_range(TB_GRID - 1);
                end
                send_toggle(r, c);
                sent++;
            end
            repeat ($urandom_range(4, 1)) begin
                send_step();
                sent++;
            end
        end
    endtask

    initial begin
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty grid stays empty
        send_step();
        // the four corners form a block across both wraps
        send_toggle(0, 0);
        send_toggle(0, TB_GRID - 1);
        send_toggle(TB_GRID - 1, 0);
        send_toggle(TB_GRID - 1, TB_GRID - 1);
        send_step();
        // clear one corner, it is born again from exactly three
        send_toggle(0, 0);
        send_step();
        // blinker straddling the column wrap
        send_toggle(15, TB_GRID - 2);
        send_toggle(15, TB_GRID - 1);
        send_toggle(15, 0);
        send_step();
        send_step();
        // lone cells with alternating coordinate bits die out
        send_toggle(10, 21);
        send_toggle(21, 10);
        send_step();
        // plus shape: the crowded centre dies
        send_toggle(5, 5);
        send_toggle(4, 5);
        send_toggle(6, 5);
        send_toggle(5, 4);
        send_toggle(5, 6);
        send_step();
        wait_drained();

        // long output hold while requests keep coming, so the core backs up
        out_hold_req = OUT_HOLD;
        send_step();
        repeat (10) send_toggle($urandom_range(TB_GRID - 1), $urandom_range(TB_GRID - 1));
        send_step();
        wait_drained();

        run_random(130);

        // swap the idling between the two sides
        send_idle_pct = 45;
        recv_idle_pct = 6;
        run_random(130);

        // both sides at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(130);

        wait_drained();
        repeat (TB_GRID + 8) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("life_automaton_grid_step_core_tb: clean");
        end else begin
            $display("life_automaton_grid_step_core_tb: errors");
        end
        $finish;
    end

endmodule
